[rtl/core/slipf_pkg.sv]
// Shared types and constants for the SLIP packet framer.
// No dependencies; imported by every module of the block.
package slipf_pkg;

  localparam logic [7:0] FRAME_END     = 8'hC0;
  localparam logic [7:0] FRAME_ESC     = 8'hDB;
  localparam logic [7:0] FRAME_ESC_END = 8'hDC;
  localparam logic [7:0] FRAME_ESC_ESC = 8'hDD;

  // Longest expansion: END, type, version, two stuffed bytes, END.
  localparam int MaxBytes = 6;
  localparam int CntW     = $clog2(MaxBytes + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_PACKET_TYPE      = 2'd0;
  localparam logic [1:0] REG_VERSION_PLAIN    = 2'd1;
  localparam logic [1:0] REG_VERSION_EXTENDED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       extended;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0] packet_type;
    logic [7:0] version_plain;
    logic [7:0] version_extended;
  } cfg_t;

  // One item's worth of framed bytes, left justified, with its length.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } burst_t;

endpackage

[rtl/core/slipf_expand.sv]
// Expands one registered input item into its framed, stuffed byte burst.
// Depends on slipf_pkg.
module slipf_expand import slipf_pkg::*; (
  input  in_item_t item,
  input  cfg_t     cfg,
  output burst_t   burst
);

  logic [CntW-1:0] pos;
  logic            is_end;
  logic            is_esc;

  always_comb begin
    is_end      = (item.data_byte == FRAME_END);
    is_esc      = (item.data_byte == FRAME_ESC);
    burst.bytes = '0;
    pos         = '0;
    // Header: opening END, type, version.
    if (item.first_of_packet) begin
      burst.bytes[0] = FRAME_END;
      burst.bytes[1] = cfg.packet_type;
      burst.bytes[2] = item.extended ? cfg.version_extended : cfg.version_plain;
      pos            = CntW'(3);
    end
    // Stuffed payload byte.
    if (is_end || is_esc) begin
      burst.bytes[pos[2:0]]         = FRAME_ESC;
      burst.bytes[pos[2:0] + 3'd1]  = is_end ? FRAME_ESC_END : FRAME_ESC_ESC;
      pos                           = pos + CntW'(2);
    end else begin
      burst.bytes[pos[2:0]] = item.data_byte;
      pos                   = pos + CntW'(1);
    end
    // Closing END.
    if (item.last_of_packet) begin
      burst.bytes[pos[2:0]] = FRAME_END;
      pos                   = pos + CntW'(1);
    end
    burst.count = pos;
  end

endmodule

[rtl/core/slipf_serializer.sv]
// Holds one burst and shifts it out one byte per accepted output item.
// Depends on slipf_pkg.
module slipf_serializer import slipf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  burst_t    burst,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [MaxBytes-1:0][7:0] bytes;
  logic [CntW-1:0]          count;
  logic                     take;

  assign out_valid         = (count != '0);
  assign take              = out_valid && out_ready;
  assign free              = !out_valid || (take && count == CntW'(1));
  assign out_item.out_byte = bytes[0];
  assign out_item.last_out = (count == CntW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.count;
    end else if (take) begin
      count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= burst.bytes;
    end else if (take) begin
      for (int i = 0; i < MaxBytes - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
      bytes[MaxBytes-1] <= '0;
    end
  end

endmodule

[rtl/core/slip_packet_framer.sv]
// Top level of the SLIP packet framer: input register, config registers,
// expander and output serializer. Depends on slipf_pkg, slipf_expand, slipf_serializer.
//
// Usage:
//   in_valid/in_ready/in_item carry one payload byte per item with the
//   first_of_packet, last_of_packet and extended flags. out_valid/out_ready/
//   out_item carry the framed stream, one byte per item; last_out marks the
//   final byte produced by an input item.
//   cfg_we/cfg_index/cfg_data write packet_type (0), version_plain (1) and
//   version_extended (2); other indexes are ignored. Write only while idle.
// Path: an accepted item is held in the input register, then loaded into
//   the output shifter, which offers its first byte.
// Throughput: one output byte per cycle while out_ready is high; an item
//   expands to 1 to 6 bytes (1 for a plain byte, +1 if stuffed, +3 on the first
//   byte of a packet, +1 on the last). The output shifter sends them one at a
//   time; the next item is loaded in the same cycle the last byte leaves, so
//   single byte items flow at one per cycle while out_ready is high.
// Reset: empties the input register and the output shifter and clears the
//   config registers to zero.
// Stall: when out_ready is low the current byte holds; the input register
//   then fills and in_ready drops until the output drains.
module slip_packet_framer import slipf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t     cfg;
  in_item_t item;
  logic     item_valid;
  logic     load;
  logic     free;
  burst_t   burst;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PACKET_TYPE:      cfg.packet_type      <= cfg_data;
        REG_VERSION_PLAIN:    cfg.version_plain    <= cfg_data;
        REG_VERSION_EXTENDED: cfg.version_extended <= cfg_data;
        default: ;
      endcase
    end
  end

  // Move the held item into the serializer as soon as it frees up.
  assign load     = item_valid && free;
  assign in_ready = !item_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  slipf_expand u_expand (
    .item  (item),
    .cfg   (cfg),
    .burst (burst)
  );

  slipf_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .burst     (burst),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[rtl/core/slipf_checker.sv]
// Port-level checks for the SLIP packet framer, bound to the top level.
// Depends on slipf_pkg and slip_packet_framer.
module slipf_checker import slipf_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input out_item_t  out_item
);

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // Reset empties the output.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Reset leaves the input register empty, so input is ready.
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // Item taken, output empty: via input register and shifter to output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind slip_packet_framer slipf_checker u_chk (.*);
